[hw/rtl/njoin_pkg.sv]
// Package for the nested-loop equi-join block: beat types, opcodes, register
// indexes and the controller state type. Depends on nothing.
`default_nettype none

package njoin_pkg;

    localparam int IN_COLS   = 4;
    localparam int JOIN_COLS = 8;

    typedef logic [63:0] word_t;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_LOAD  = 2'd0;
    localparam opcode_t OP_PROBE = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    typedef logic [7:0] cfg_index_t;
    typedef logic [7:0] cfg_data_t;
    localparam cfg_index_t CFG_PROBE_KEY   = 8'd0;
    localparam cfg_index_t CFG_BUILD_KEY   = 8'd1;
    localparam cfg_index_t CFG_PROBE_COUNT = 8'd2;
    localparam cfg_index_t CFG_BUILD_COUNT = 8'd3;

    typedef struct packed {
        opcode_t opcode;
        word_t   in_col0;
        word_t   in_col1;
        word_t   in_col2;
        word_t   in_col3;
    } item_t;

    typedef struct packed {
        word_t out_col0;
        word_t out_col1;
        word_t out_col2;
        word_t out_col3;
        word_t out_col4;
        word_t out_col5;
        word_t out_col6;
        word_t out_col7;
        logic  last_match;
        logic  capacity_full;
    } result_t;

    typedef struct packed {
        logic load;
        logic rotate;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/njoin_item_if.sv]
// Input channel of the join block: one row beat with its opcode.
// Depends on njoin_pkg.
`default_nettype none

interface njoin_item_if;
    logic               valid;
    logic               ready;
    njoin_pkg::item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/njoin_result_if.sv]
// Output channel of the join block: one joined row beat with its flags.
// Depends on njoin_pkg.
`default_nettype none

interface njoin_result_if;
    logic               valid;
    logic               ready;
    njoin_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/njoin_cfg_if.sv]
// Register write channel of the join block: register index and write data.
// Depends on njoin_pkg.
`default_nettype none

interface njoin_cfg_if;
    logic                  valid;
    logic                  ready;
    njoin_pkg::cfg_index_t index;
    njoin_pkg::cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/njoin_cell.sv]
// One slot of the build-row ring: holds one stored row, takes a new row when
// its slot is loaded and the neighbor's row when the ring turns. Uses njoin_pkg.
`default_nettype none

module njoin_cell #(
    parameter int COLS  = 4,
    parameter int IDX   = 0,
    parameter int SLOT_W = 6
) (
    input  wire                       clk,
    input  wire njoin_pkg::cell_ctl_t ctl,
    input  wire [SLOT_W-1:0]          slot,
    input  wire njoin_pkg::word_t     load_row [COLS],
    input  wire njoin_pkg::word_t     next_row [COLS],
    output njoin_pkg::word_t          row      [COLS]
);

    njoin_pkg::word_t row_reg  [COLS];
    njoin_pkg::word_t row_next [COLS];

    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            row_next[c] = row_reg[c];
            if (ctl.load && (slot == SLOT_W'(IDX)))
            begin
                row_next[c] = load_row[c];
            end
            else if (ctl.rotate)
            begin
                row_next[c] = next_row[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < COLS; c++)
        begin
            row_reg[c] <= row_next[c];
        end
    end

    assign row = row_reg;

endmodule

`default_nettype wire

[hw/rtl/nested_loop_equi_join_top.sv]
// Top level of the nested-loop equi-join: register file, ring of build-row
// cells, probe walker and output stage. Uses njoin_pkg, the channel
// interfaces and njoin_cell.
//
//   channel | dir | beat
//   item    | in  | opcode + four 64-bit columns (load, probe, clear)
//   result  | out | eight 64-bit joined columns, last_match, capacity_full
//   cfg     | in  | register index + write data, always ready
//
// Load and clear complete in idle. A probe turns the ring of cells once,
// one stored row reaching cell zero's compare per cycle unless a stalled
// result holds the ring until the output register frees up; then the held
// last match is flushed. Reset clears the row count, emitted count and
// overflow flag and sets the key registers to zero and the counts to four;
// stored rows are undefined until loaded.
`default_nettype none

module nested_loop_equi_join_top #(
    parameter int BUILD_ROWS      = 32,
    parameter int MAX_COLUMNS     = 4,
    parameter int OUTPUT_CAPACITY = 1000
) (
    input  wire              clk,
    input  wire              rst_n,
    njoin_item_if.sink       item,
    njoin_result_if.source   result,
    njoin_cfg_if.sink        cfg
);

    localparam int CNT_W  = $clog2(BUILD_ROWS + 1);
    localparam int STEP_W = (BUILD_ROWS > 1) ? $clog2(BUILD_ROWS) : 1;
    localparam int EMIT_W = $clog2(OUTPUT_CAPACITY + 1);
    localparam logic [2:0] MAXC = 3'(MAX_COLUMNS);
    localparam logic [1:0] MAXK = 2'(MAX_COLUMNS - 1);

    njoin_pkg::state_t   state_reg, state_next;
    logic [1:0]          probe_key_reg;
    logic [1:0]          build_key_reg;
    logic [2:0]          probe_count_reg;
    logic [2:0]          build_count_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [EMIT_W-1:0]   emitted_reg, emitted_next;
    logic                overflow_reg, overflow_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                pending_valid_reg, pending_valid_next;
    njoin_pkg::result_t  pending_data_reg, pending_data_next;
    logic                out_valid_reg, out_valid_next;
    njoin_pkg::result_t  out_data_reg, out_data_next;
    njoin_pkg::word_t    probe_reg [njoin_pkg::IN_COLS];
    njoin_pkg::word_t    probe_next [njoin_pkg::IN_COLS];
    njoin_pkg::word_t    key_reg, key_next;

    njoin_pkg::word_t    in_cols  [njoin_pkg::IN_COLS];
    njoin_pkg::word_t    load_row [MAX_COLUMNS];
    njoin_pkg::word_t    ring_row [BUILD_ROWS][MAX_COLUMNS];
    njoin_pkg::word_t    join_cols [njoin_pkg::JOIN_COLS];
    njoin_pkg::word_t    build_key_val;
    njoin_pkg::cell_ctl_t cell_ctl;
    njoin_pkg::result_t  joined;

    logic [2:0]          pc;
    logic [2:0]          bc;
    logic [1:0]          pk;
    logic [1:0]          bk;
    logic                item_accept;
    logic                out_free;
    logic                hit;
    logic                take;
    logic                push;
    logic                advance;
    logic [EMIT_W-1:0]   emitted_inc;

    // register file
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_key_reg   <= 2'd0;
            build_key_reg   <= 2'd0;
            probe_count_reg <= 3'd4;
            build_count_reg <= 3'd4;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                njoin_pkg::CFG_PROBE_KEY:   probe_key_reg   <= cfg.data[1:0];
                njoin_pkg::CFG_BUILD_KEY:   build_key_reg   <= cfg.data[1:0];
                njoin_pkg::CFG_PROBE_COUNT: probe_count_reg <= cfg.data[2:0];
                njoin_pkg::CFG_BUILD_COUNT: build_count_reg <= cfg.data[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pc = (probe_count_reg == 3'd0) ? 3'd1 :
             (probe_count_reg > MAXC) ? MAXC : probe_count_reg;
        bc = (build_count_reg == 3'd0) ? 3'd1 :
             (build_count_reg > MAXC) ? MAXC : build_count_reg;
        pk = (probe_key_reg > MAXK) ? MAXK : probe_key_reg;
        bk = (build_key_reg > MAXK) ? MAXK : build_key_reg;
    end

    // ring of build-row cells; cell zero faces the compare
    assign in_cols[0] = item.data.in_col0;
    assign in_cols[1] = item.data.in_col1;
    assign in_cols[2] = item.data.in_col2;
    assign in_cols[3] = item.data.in_col3;

    always_comb
    begin
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            load_row[c] = in_cols[c];
        end
    end

    for (genvar i = 0; i < BUILD_ROWS; i++)
    begin : g_cell
        njoin_cell #(
            .COLS   (MAX_COLUMNS),
            .IDX    (i),
            .SLOT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .ctl      (cell_ctl),
            .slot     (count_reg),
            .load_row (load_row),
            .next_row (ring_row[(i + 1) % BUILD_ROWS]),
            .row      (ring_row[i])
        );
    end

    // key compare and joined-row assembly on cell zero
    always_comb
    begin
        build_key_val = '0;
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            if (2'(c) == bk)
            begin
                build_key_val = ring_row[0][c];
            end
        end
        for (int j = 0; j < njoin_pkg::JOIN_COLS; j++)
        begin
            join_cols[j] = '0;
            for (int c = 0; c < njoin_pkg::IN_COLS; c++)
            begin
                if ((3'(c) < pc) && (c == j))
                begin
                    join_cols[j] = probe_reg[c];
                end
            end
            for (int c = 0; c < MAX_COLUMNS; c++)
            begin
                if ((3'(c) < bc) && (({1'b0, pc} + 4'(c)) == 4'(j)))
                begin
                    join_cols[j] = ring_row[0][c];
                end
            end
        end
    end

    assign emitted_inc = emitted_reg + EMIT_W'(1);

    always_comb
    begin
        joined.out_col0      = join_cols[0];
        joined.out_col1      = join_cols[1];
        joined.out_col2      = join_cols[2];
        joined.out_col3      = join_cols[3];
        joined.out_col4      = join_cols[4];
        joined.out_col5      = join_cols[5];
        joined.out_col6      = join_cols[6];
        joined.out_col7      = join_cols[7];
        joined.last_match    = 1'b0;
        joined.capacity_full = overflow_reg ||
                               (emitted_inc == EMIT_W'(OUTPUT_CAPACITY));
    end

    // walker and output stage
    assign item.ready   = (state_reg == njoin_pkg::ST_IDLE);
    assign item_accept  = item.valid && item.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign hit          = (state_reg == njoin_pkg::ST_WALK) &&
                          (CNT_W'(step_reg) < count_reg) &&
                          (build_key_val == key_reg);
    assign take         = hit && (emitted_reg < EMIT_W'(OUTPUT_CAPACITY));
    assign push         = take && pending_valid_reg;
    assign advance      = !push || out_free;

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        emitted_next       = emitted_reg;
        overflow_next      = overflow_reg;
        step_next          = step_reg;
        pending_valid_next = pending_valid_reg;
        pending_data_next  = pending_data_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        probe_next         = probe_reg;
        key_next           = key_reg;
        cell_ctl           = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            njoin_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    case (item.data.opcode)
                        njoin_pkg::OP_LOAD:
                        begin
                            if (count_reg < CNT_W'(BUILD_ROWS))
                            begin
                                cell_ctl.load = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        njoin_pkg::OP_PROBE:
                        begin
                            probe_next         = in_cols;
                            key_next           = in_cols[pk];
                            step_next          = '0;
                            pending_valid_next = 1'b0;
                            state_next         = njoin_pkg::ST_WALK;
                        end
                        njoin_pkg::OP_CLEAR:
                        begin
                            count_next    = '0;
                            emitted_next  = '0;
                            overflow_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            njoin_pkg::ST_WALK:
            begin
                if (advance)
                begin
                    cell_ctl.rotate = 1'b1;
                    step_next       = step_reg + STEP_W'(1);
                    if (hit && !take)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (take)
                    begin
                        if (pending_valid_reg)
                        begin
                            out_data_next  = pending_data_reg;
                            out_valid_next = 1'b1;
                        end
                        pending_data_next  = joined;
                        pending_valid_next = 1'b1;
                        emitted_next       = emitted_inc;
                    end
                    if (step_reg == STEP_W'(BUILD_ROWS - 1))
                    begin
                        state_next = njoin_pkg::ST_FLUSH;
                    end
                end
            end
            njoin_pkg::ST_FLUSH:
            begin
                if (!pending_valid_reg)
                begin
                    state_next = njoin_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_data_next               = pending_data_reg;
                    out_data_next.last_match    = 1'b1;
                    out_data_next.capacity_full = pending_data_reg.capacity_full ||
                                                  overflow_reg;
                    out_valid_next              = 1'b1;
                    pending_valid_next          = 1'b0;
                    state_next                  = njoin_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = njoin_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= njoin_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            emitted_reg       <= '0;
            overflow_reg      <= 1'b0;
            step_reg          <= '0;
            pending_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            count_reg         <= count_next;
            emitted_reg       <= emitted_next;
            overflow_reg      <= overflow_next;
            step_reg          <= step_next;
            pending_valid_reg <= pending_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pending_data_reg <= pending_data_next;
        out_data_reg     <= out_data_next;
        probe_reg        <= probe_next;
        key_reg          <= key_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

`default_nettype wire

[hw/rtl/njoin_checker.sv]
// Port-level checks for the nested-loop equi-join top level, and the bind
// that attaches them. Uses njoin_pkg.
`default_nettype none

module njoin_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     item_valid,
    input wire                     item_ready,
    input wire njoin_pkg::item_t   item_data,
    input wire                     result_valid,
    input wire                     result_ready,
    input wire njoin_pkg::result_t result_data
);

    // a probe beat occupies the block
    a_probe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_data.opcode == njoin_pkg::OP_PROBE)
        |=> !item_ready)
        else $error("item ready after probe beat");

    // load, clear and unused-opcode beats leave the block ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_data.opcode != njoin_pkg::OP_PROBE)
        |=> item_ready)
        else $error("item ready dropped after non-probe beat");

    // hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result beat changed while stalled");

endmodule

bind nested_loop_equi_join_top njoin_checker u_njoin_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_data    (item.data),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

`default_nettype wire

[sim/nested_loop_equi_join_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for nested_loop_equi_join_top: a table of directed rows, random build/probe
// rounds under varied register settings, then a run up to the output capacity.
// Beats are checked against the table or a behavioral join model. Depends on njoin_pkg.

module nested_loop_equi_join_top_tb;

    localparam int STORE_ROWS    = 32;
    localparam int CAPACITY      = 1000;
    localparam int SETTLE_CYCLES = STORE_ROWS + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 50;
    localparam int DRAIN_LIMIT   = 200000;

    localparam njoin_pkg::opcode_t OP_UNUSED = 2'd3;

    localparam njoin_pkg::word_t W0 = 64'h0;
    localparam njoin_pkg::word_t W1 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam njoin_pkg::word_t W5 = 64'h5555_5555_5555_5555;
    localparam njoin_pkg::word_t WA = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam njoin_pkg::word_t KD = 64'hDEAD_BEEF_CAFE_F00D;

    typedef struct {
        int                 count;
        njoin_pkg::result_t res;
    } typed_t;

    typedef struct {
        bit                    is_write;
        njoin_pkg::cfg_index_t idx;
        njoin_pkg::cfg_data_t  val;
        njoin_pkg::item_t      row;
        typed_t                want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    njoin_item_if   item_ch ();
    njoin_result_if res_ch ();
    njoin_cfg_if    cfg_ch ();

    nested_loop_equi_join_top #(
        .BUILD_ROWS      (STORE_ROWS),
        .MAX_COLUMNS     (njoin_pkg::IN_COLS),
        .OUTPUT_CAPACITY (CAPACITY)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    njoin_pkg::word_t   stored_rows [STORE_ROWS][njoin_pkg::IN_COLS];
    int                 rows_held;
    int                 rows_joined;
    bit                 matches_dropped;
    logic [1:0]         probe_key_sel;
    logic [1:0]         build_key_sel;
    logic [2:0]         probe_width;
    logic [2:0]         build_width;

    njoin_pkg::result_t joined_now [$];
    njoin_pkg::result_t joined_due [$];
    typed_t             typed_due [$];
    plan_row_t          plan [$];

    int                 errors;
    bit                 gaps_on;
    int                 burst_left;
    int                 stall_mode;
    int                 stall_tick;
    bit                 hold_req;
    int                 hold_left;
    njoin_pkg::word_t   key_pool [4];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task report_mismatch(input string what, input njoin_pkg::word_t got,
                         input njoin_pkg::word_t want);
        errors++;
        if (errors <= 40)
            $display("%0t ns: %s got %h expected %h", $time, what, got, want);
    endtask

    function automatic int eff_width(logic [2:0] w);
        if (w == 3'd0)
            return 1;
        if (w > njoin_pkg::IN_COLS)
            return njoin_pkg::IN_COLS;
        return w;
    endfunction

    function automatic void join_row(njoin_pkg::item_t it);
        njoin_pkg::word_t   pcol [njoin_pkg::IN_COLS];
        njoin_pkg::word_t   jc [njoin_pkg::JOIN_COLS];
        njoin_pkg::word_t   key;
        int                 pw;
        int                 bw;
        njoin_pkg::result_t r;
        joined_now.delete();
        pcol[0] = it.in_col0;
        pcol[1] = it.in_col1;
        pcol[2] = it.in_col2;
        pcol[3] = it.in_col3;
        case (it.opcode)
            njoin_pkg::OP_LOAD:
            begin
                if (rows_held < STORE_ROWS)
                begin
                    for (int c = 0; c < njoin_pkg::IN_COLS; c++)
                        stored_rows[rows_held][c] = pcol[c];
                    rows_held++;
                end
            end
            njoin_pkg::OP_CLEAR:
            begin
                rows_held = 0;
                rows_joined = 0;
                matches_dropped = 1'b0;
            end
            njoin_pkg::OP_PROBE:
            begin
                pw = eff_width(probe_width);
                bw = eff_width(build_width);
                key = pcol[probe_key_sel];
                for (int i = 0; i < rows_held; i++)
                begin
                    if (stored_rows[i][build_key_sel] != key)
                        continue;
                    if (rows_joined >= CAPACITY)
                    begin
                        matches_dropped = 1'b1;
                        continue;
                    end
                    foreach (jc[c])
                        jc[c] = '0;
                    for (int c = 0; c < pw; c++)
                        jc[c] = pcol[c];
                    for (int c = 0; c < bw; c++)
                        jc[pw + c] = stored_rows[i][c];
                    rows_joined++;
                    r = njoin_pkg::result_t'{jc[0], jc[1], jc[2], jc[3],
                                             jc[4], jc[5], jc[6], jc[7], 1'b0,
                                             matches_dropped || rows_joined >= CAPACITY};
                    joined_now.push_back(r);
                end
                if (joined_now.size() > 0)
                begin
                    r = joined_now.pop_back();
                    r.last_match = 1'b1;
                    r.capacity_full = r.capacity_full | matches_dropped;
                    joined_now.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin : port_watch
        njoin_pkg::result_t got;
        njoin_pkg::result_t want;
        typed_t             ov;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.data;
                if (joined_due.size() == 0)
                    report_mismatch("unexpected beat, out_col0", got.out_col0, '0);
                else
                begin
                    want = joined_due.pop_front();
                    for (int f = 0; f < njoin_pkg::JOIN_COLS; f++)
                        if (got[2 + 64 * (njoin_pkg::JOIN_COLS - 1 - f) +: 64]
                            !== want[2 + 64 * (njoin_pkg::JOIN_COLS - 1 - f) +: 64])
                            report_mismatch($sformatf("out_col%0d", f),
                                got[2 + 64 * (njoin_pkg::JOIN_COLS - 1 - f) +: 64],
                                want[2 + 64 * (njoin_pkg::JOIN_COLS - 1 - f) +: 64]);
                    if (got.last_match !== want.last_match)
                        report_mismatch("last_match", got.last_match, want.last_match);
                    if (got.capacity_full !== want.capacity_full)
                        report_mismatch("capacity_full", got.capacity_full, want.capacity_full);
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                join_row(item_ch.data);
                if (typed_due.size() > 0)
                    ov = typed_due.pop_front();
                else
                    ov.count = -1;
                if (ov.count < 0)
                    foreach (joined_now[k])
                        joined_due.push_back(joined_now[k]);
                else if (ov.count > 0)
                    joined_due.push_back(ov.res);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    njoin_pkg::CFG_PROBE_KEY:   probe_key_sel = cfg_ch.data[1:0];
                    njoin_pkg::CFG_BUILD_KEY:   build_key_sel = cfg_ch.data[1:0];
                    njoin_pkg::CFG_PROBE_COUNT: probe_width = cfg_ch.data[2:0];
                    njoin_pkg::CFG_BUILD_COUNT: build_width = cfg_ch.data[2:0];
                    default: ;
                endcase
            end
        end
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: res_ch.ready <= ((stall_tick % 7) < 3);
                    default: res_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            stall_tick++;
        end
    end

    function automatic typed_t typed(int n, njoin_pkg::result_t r = '0);
        typed_t t;
        t.count = n;
        t.res = r;
        return t;
    endfunction

    function automatic plan_row_t item_row(njoin_pkg::item_t it, int n = -1,
                                           njoin_pkg::result_t r = '0);
        plan_row_t p;
        p.is_write = 1'b0;
        p.idx = '0;
        p.val = '0;
        p.row = it;
        p.want = typed(n, r);
        return p;
    endfunction

    function automatic plan_row_t reg_row(njoin_pkg::cfg_index_t idx,
                                          njoin_pkg::cfg_data_t val);
        plan_row_t p;
        p.is_write = 1'b1;
        p.idx = idx;
        p.val = val;
        p.row = '0;
        p.want = typed(0);
        return p;
    endfunction

    function automatic njoin_pkg::word_t rnd_word();
        return {$urandom, $urandom};
    endfunction

    function automatic njoin_pkg::word_t pick_key(bit narrow);
        if (narrow)
            return key_pool[0];
        if ($urandom_range(0, 4) == 0)
            return rnd_word();
        return key_pool[$urandom_range(0, 3)];
    endfunction

    function automatic njoin_pkg::item_t rnd_row(njoin_pkg::opcode_t op, int key_at,
                                                 njoin_pkg::word_t key);
        njoin_pkg::word_t c [njoin_pkg::IN_COLS];
        foreach (c[k])
            c[k] = rnd_word();
        if (key_at >= 0)
            c[key_at] = key;
        return njoin_pkg::item_t'{op, c[0], c[1], c[2], c[3]};
    endfunction

    task push_row(input njoin_pkg::item_t it, input typed_t want);
        int gap;
        if (cfg_ch.valid)
            cfg_ch.valid <= 1'b0;
        if (gaps_on && burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        typed_due.push_back(want);
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task write_reg(input njoin_pkg::cfg_index_t idx, input njoin_pkg::cfg_data_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task drain_results();
        item_ch.valid <= 1'b0;
        while (joined_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int                    rand_count;
        int                    round_no;
        int                    n;
        int                    spins;
        bit                    narrow;
        njoin_pkg::cfg_index_t idx;
        njoin_pkg::cfg_data_t  val;
        njoin_pkg::word_t      cap_key;

        errors = 0;
        rows_held = 0;
        rows_joined = 0;
        matches_dropped = 1'b0;
        probe_key_sel = 2'd0;
        build_key_sel = 2'd0;
        probe_width = 3'd4;
        build_width = 3'd4;
        gaps_on = 1'b1;
        burst_left = 0;
        stall_mode = 1;
        stall_tick = 0;
        hold_req = 1'b0;
        hold_left = 0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        rst_n = 1'b0;

        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE, W0, W0, W0, W0}, 0));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_LOAD, W0, W1, W5, WA}, 0));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE, W0, 64'd1, 64'd2,
                                                   64'd3}, 1,
                                njoin_pkg::result_t'{W0, 64'd1, 64'd2, 64'd3, W0, W1, W5, WA,
                                                     1'b1, 1'b0}));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_LOAD, W1, W0, WA, W5}, 0));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE, W1, W5, WA, W0}, 1,
                                njoin_pkg::result_t'{W1, W5, WA, W0, W1, W0, WA, W5,
                                                     1'b1, 1'b0}));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_LOAD, W0,
                                                   64'h0123_4567_89AB_CDEF,
                                                   64'hFEDC_BA98_7654_3210,
                                                   64'h8000_0000_0000_0000}, 0));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE, W0, WA, W5, W1}));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE,
                                                   64'h8000_0000_0000_0000, W0, W0, W0}, 0));
        plan.push_back(item_row(njoin_pkg::item_t'{OP_UNUSED, W1, W1, W1, W1}, 0));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE, W0, W1, W1, W1}));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_CLEAR, W1, W1, W1, W1}, 0));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE, W0, W0, W0, W0}, 0));
        plan.push_back(reg_row(njoin_pkg::CFG_PROBE_KEY, 8'd3));
        plan.push_back(reg_row(njoin_pkg::CFG_BUILD_KEY, 8'd2));
        plan.push_back(reg_row(njoin_pkg::CFG_PROBE_COUNT, 8'd1));
        plan.push_back(reg_row(njoin_pkg::CFG_BUILD_COUNT, 8'd3));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_LOAD, 64'd10, 64'd11, KD,
                                                   64'd13}, 0));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE, 64'd20, 64'd21,
                                                   64'd22, KD}, 1,
                                njoin_pkg::result_t'{64'd20, 64'd10, 64'd11, KD,
                                                     W0, W0, W0, W0, 1'b1, 1'b0}));
        plan.push_back(reg_row(njoin_pkg::CFG_PROBE_COUNT, 8'd0));
        plan.push_back(reg_row(njoin_pkg::CFG_BUILD_COUNT, 8'd7));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_LOAD, KD, W1, KD, W0}, 0));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE, W1, W0, W5, KD}));
        plan.push_back(reg_row(8'd9, 8'hFF));
        plan.push_back(reg_row(njoin_pkg::CFG_PROBE_COUNT, 8'hFC));
        plan.push_back(item_row(njoin_pkg::item_t'{njoin_pkg::OP_PROBE, WA, W5, W0, KD}));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                if (i == 0 || !plan[i - 1].is_write)
                    drain_results();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                push_row(plan[i].row, plan[i].want);
        end

        rand_count = 0;
        round_no = 0;
        while (rand_count < RANDOM_ITEMS)
        begin
            drain_results();
            n = $urandom_range(1, 4);
            for (int w = 0; w < n; w++)
            begin
                if ($urandom_range(0, 7) == 0)
                    idx = njoin_pkg::cfg_index_t'($urandom_range(
                              njoin_pkg::CFG_BUILD_COUNT + 1, 255));
                else
                    idx = njoin_pkg::cfg_index_t'($urandom_range(
                              njoin_pkg::CFG_PROBE_KEY, njoin_pkg::CFG_BUILD_COUNT));
                case ($urandom_range(0, 4))
                    0: val = 8'd0;
                    1: val = 8'd1;
                    2: val = 8'd3;
                    3: val = 8'd4;
                    default: val = njoin_pkg::cfg_data_t'($urandom_range(0, 255));
                endcase
                write_reg(idx, val);
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_mode = $urandom_range(0, 3);
            narrow = (round_no == 1);
            key_pool[0] = rnd_word();
            key_pool[1] = W0;
            key_pool[2] = W1;
            key_pool[3] = rnd_word();

            if ($urandom_range(0, 3) != 0)
            begin
                push_row(rnd_row(njoin_pkg::OP_CLEAR, -1, '0), typed(-1));
                rand_count++;
            end
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(STORE_ROWS, STORE_ROWS + 4);
            else
                n = $urandom_range(1, 8);
            for (int j = 0; j < n; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_row(rnd_row(OP_UNUSED, -1, '0), typed(-1));
                push_row(rnd_row(njoin_pkg::OP_LOAD, build_key_sel, pick_key(narrow)),
                         typed(-1));
                if (j < STORE_ROWS)
                    rand_count++;
            end

            if (narrow)
            begin
                hold_req = 1'b1;
                n = 8;
            end
            else
                n = $urandom_range(2, 10);
            for (int j = 0; j < n; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_row(rnd_row(OP_UNUSED, -1, '0), typed(-1));
                if ($urandom_range(0, 7) == 0)
                    push_row(rnd_row(njoin_pkg::OP_LOAD, build_key_sel, pick_key(narrow)),
                             typed(-1));
                else
                    push_row(rnd_row(njoin_pkg::OP_PROBE, probe_key_sel, pick_key(narrow)),
                             typed(-1));
                rand_count++;
            end
            round_no++;
        end

        drain_results();
        write_reg(njoin_pkg::CFG_PROBE_KEY, 8'd1);
        write_reg(njoin_pkg::CFG_BUILD_KEY, 8'd2);
        write_reg(njoin_pkg::CFG_PROBE_COUNT, 8'd2);
        write_reg(njoin_pkg::CFG_BUILD_COUNT, 8'd3);
        gaps_on = 1'b0;
        stall_mode = 1;
        cap_key = 64'h8000_0000_0000_0001;
        push_row(rnd_row(njoin_pkg::OP_CLEAR, -1, '0), typed(-1));
        for (int j = 0; j <= STORE_ROWS; j++)
            push_row(rnd_row(njoin_pkg::OP_LOAD, 2,
                             (j % 4 == 3 && j < 28) ? rnd_word() : cap_key),
                     typed(-1));
        for (int j = 0; j < 41; j++)
            push_row(rnd_row(njoin_pkg::OP_PROBE, 1, cap_key), typed(-1));
        push_row(rnd_row(njoin_pkg::OP_CLEAR, -1, '0), typed(-1));
        push_row(rnd_row(njoin_pkg::OP_LOAD, 2, cap_key), typed(-1));
        push_row(rnd_row(njoin_pkg::OP_PROBE, 1, cap_key), typed(-1));

        item_ch.valid <= 1'b0;
        stall_mode = 0;
        spins = 0;
        while (joined_due.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (joined_due.size() != 0)
            report_mismatch("beats never returned", joined_due.size(), 0);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
